>>> rtl/core/sbfr_pkg.sv
// shared types and constants for the seven-bit frame receiver
`default_nettype none

package sbfr_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CodeW     = 7;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CountW    = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 40;

  localparam logic [CountW-1:0] MaxChunks = CountW'(5);

  localparam logic [CodeW-1:0] StartCodeReset = CodeW'(1);
  localparam logic [CodeW-1:0] EndCodeReset   = CodeW'(2);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStartCode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgEndCode   = 1'b1;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhType  = 2'd1,
    PhData  = 2'd2,
    PhCheck = 2'd3
  } phase_e;

  // one validated frame
  typedef struct packed {
    logic [CodeW-1:0] msg_type;
    logic [WordW-1:0] data_word;
    logic             word_present;
  } result_t;

  // current control codes
  typedef struct packed {
    logic [CodeW-1:0] start_code;
    logic [CodeW-1:0] end_code;
  } codes_t;

endpackage

`default_nettype wire

>>> rtl/core/seven_bit_frame_receiver.sv
// top level of the seven-bit frame receiver
//
// Slave channel: one received byte per request on s_axis_tdata. Bit 7 set
// marks a control byte whose low seven bits are matched against the start
// and end codes; other bytes are type, data chunks or the check byte.
// Master channel: one request per validated frame, carrying the type and the
// assembled 32-bit word in m_axis_tdata and the word-present flag in
// m_axis_tuser. Bad or aborted frames produce nothing.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 start code, 1 end code) at the clock edge; write only while idle.
// Path: a byte taken into the input register is processed from there and its
// result is loaded into the result register, so m_axis_tvalid rises when the
// outcome of the check byte is loaded.
// Throughput: one byte per cycle while the result register is free, set by the
// state update between the input register and the result register.
// Reset: rst_ni low clears the frame state to idle, drops both pipeline
// registers and restores start code 1 and end code 2.
// Stall: while m_axis_tready is low with a result held, the byte in the
// input register waits and s_axis_tready stays low until the result is taken.
`default_nettype none

module seven_bit_frame_receiver (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [sbfr_pkg::InTdataW-1:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [sbfr_pkg::OutTdataW-1:0]       m_axis_tdata,   // [6:0] msg_type,
                                                               // [38:7] data_word, [39] zero
  output logic                                 m_axis_tuser,   // [0] word_present
  input  wire logic                            cfg_we_i,
  input  wire logic [sbfr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [sbfr_pkg::CodeW-1:0]      cfg_wdata_i
);

  logic                       byte_valid;
  logic [sbfr_pkg::ByteW-1:0] byte_q_w;
  logic                       step;
  logic                       out_free;
  logic                       res_valid;
  sbfr_pkg::result_t          res;
  sbfr_pkg::result_t          res_out;
  sbfr_pkg::codes_t           codes_q;

  // control code registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.start_code <= sbfr_pkg::StartCodeReset;
      codes_q.end_code   <= sbfr_pkg::EndCodeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbfr_pkg::CfgStartCode: codes_q.start_code <= cfg_wdata_i;
        sbfr_pkg::CfgEndCode:   codes_q.end_code   <= cfg_wdata_i;
        default:                codes_q            <= codes_q;
      endcase
    end
  end

  // a byte is processed when the result register can take its outcome
  assign step = byte_valid && out_free;

  sbfr_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata[sbfr_pkg::ByteW-1:0]),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_q_w),
    .take_i       (step)
  );

  sbfr_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q_w),
    .codes_i     (codes_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sbfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res_out)
  );

  // pack the master-side payload
  assign m_axis_tdata = {1'b0, res_out.data_word, res_out.msg_type};
  assign m_axis_tuser = res_out.word_present;

endmodule

`default_nettype wire

>>> rtl/core/sbfr_in_stage.sv
// input register for received bytes
`default_nettype none

module sbfr_in_stage (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [sbfr_pkg::ByteW-1:0] in_byte_i,
  output logic                           byte_valid_o,
  output logic [sbfr_pkg::ByteW-1:0]     byte_o,
  input  wire logic                      take_i
);

  logic                       valid_q, valid_d;
  logic [sbfr_pkg::ByteW-1:0] byte_q;

  // room when empty or when the held byte leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload has no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

`default_nettype wire

>>> rtl/core/sbfr_frame_core.sv
// frame state machine, word assembly and check
`default_nettype none

module sbfr_frame_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic [sbfr_pkg::ByteW-1:0] byte_i,
  input  wire sbfr_pkg::codes_t           codes_i,
  output logic                            res_valid_o,
  output sbfr_pkg::result_t               res_o
);

  sbfr_pkg::phase_e                phase_q, phase_d;
  logic [sbfr_pkg::CountW-1:0]     count_q, count_d;
  logic [sbfr_pkg::CodeW-1:0]      parity_q, parity_d;
  logic [sbfr_pkg::CodeW-1:0]      type_q, type_d;
  logic [sbfr_pkg::WordW-1:0]      word_q, word_d;
  logic [sbfr_pkg::CodeW-1:0]      val;
  logic                            is_ctrl;
  logic [sbfr_pkg::WordW-1:0]      chunk_bits;

  assign val     = byte_i[sbfr_pkg::CodeW-1:0];
  assign is_ctrl = byte_i[sbfr_pkg::ByteW-1];

  // place the chunk by its position in the word
  always_comb begin
    unique case (count_q)
      3'd0:    chunk_bits = {val, 25'd0};
      3'd1:    chunk_bits = {7'd0, val, 18'd0};
      3'd2:    chunk_bits = {14'd0, val, 11'd0};
      3'd3:    chunk_bits = {21'd0, val, 4'd0};
      default: chunk_bits = {28'd0, val[6:3]};
    endcase
  end

  // next state and result for one byte
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    parity_d    = parity_q;
    type_d      = type_q;
    word_d      = word_q;
    res_valid_o = 1'b0;
    res_o.msg_type     = type_q;
    res_o.data_word    = word_q;
    res_o.word_present = (count_q == sbfr_pkg::MaxChunks);
    if (step_i) begin
      if (is_ctrl) begin
        priority if (val == codes_i.start_code) begin
          word_d  = '0;
          count_d = '0;
          phase_d = sbfr_pkg::PhType;
        end else if (val == codes_i.end_code) begin
          phase_d = (phase_q == sbfr_pkg::PhData) ? sbfr_pkg::PhCheck : sbfr_pkg::PhIdle;
        end else begin
          phase_d = phase_q;
        end
      end else begin
        unique case (phase_q)
          sbfr_pkg::PhType: begin
            type_d   = val;
            parity_d = val;
            phase_d  = sbfr_pkg::PhData;
          end
          sbfr_pkg::PhData: begin
            if (count_q < sbfr_pkg::MaxChunks) begin
              word_d   = word_q | chunk_bits;
              count_d  = count_q + 3'd1;
              parity_d = parity_q ^ val;
            end else begin
              // sixth chunk aborts the frame
              phase_d = sbfr_pkg::PhIdle;
            end
          end
          sbfr_pkg::PhCheck: begin
            phase_d     = sbfr_pkg::PhIdle;
            res_valid_o = (parity_q == val) &&
                          ((count_q == '0) || (count_q == sbfr_pkg::MaxChunks));
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sbfr_pkg::PhIdle;
      count_q  <= '0;
      parity_q <= '0;
      type_q   <= '0;
      word_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      parity_q <= parity_d;
      type_q   <= type_d;
      word_q   <= word_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sbfr_out_stage.sv
// result register toward the master side
`default_nettype none

module sbfr_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire logic              res_valid_i,
  input  wire sbfr_pkg::result_t res_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sbfr_pkg::result_t      res_o
);

  logic              valid_q, valid_d;
  sbfr_pkg::result_t res_q;

  // free when empty or when the held result is taken now
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> test/tb.sv
// testbench for the seven-bit frame receiver: byte stream in, checked frames out
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles = 8;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [sbfr_pkg::InTdataW-1:0]       s_axis_tdata;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [sbfr_pkg::OutTdataW-1:0]      m_axis_tdata;
  logic                                m_axis_tuser;
  logic                                cfg_we_i;
  logic [sbfr_pkg::CfgIdxW-1:0]        cfg_idx_i;
  logic [sbfr_pkg::CodeW-1:0]          cfg_wdata_i;

  // frame tracker state, mirrors the receiver
  logic [sbfr_pkg::CodeW-1:0]  start_code;
  logic [sbfr_pkg::CodeW-1:0]  end_code;
  sbfr_pkg::phase_e            rx_phase;
  logic [sbfr_pkg::CountW-1:0] chunk_cnt;
  logic [sbfr_pkg::CodeW-1:0]  xor_sum;
  logic [sbfr_pkg::CodeW-1:0]  cur_type;
  logic [sbfr_pkg::WordW-1:0]  word_acc;

  sbfr_pkg::result_t pending_frames[$];
  int                mismatches = 0;
  int                bytes_sent = 0;
  int                sender_idle_pct = 0;
  int                sink_stall_pct = 0;

  seven_bit_frame_receiver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [6:0] msg_type, [38:7] data_word, [39] zero
    .m_axis_tuser  (m_axis_tuser),   // [0] word_present
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // update the frame tracker with one accepted byte, queue a frame when it validates
  task automatic track_byte(input logic [sbfr_pkg::ByteW-1:0] rx);
    logic [sbfr_pkg::CodeW-1:0] v;
    sbfr_pkg::result_t          frame;
    v = rx[sbfr_pkg::CodeW-1:0];
    if (rx[sbfr_pkg::ByteW-1]) begin
      if (v == start_code) begin
        word_acc  = '0;
        chunk_cnt = '0;
        rx_phase  = sbfr_pkg::PhType;
      end else if (v == end_code) begin
        if (rx_phase == sbfr_pkg::PhData) rx_phase = sbfr_pkg::PhCheck;
        else rx_phase = sbfr_pkg::PhIdle;
      end
    end else begin
      case (rx_phase)
        sbfr_pkg::PhType: begin
          cur_type = v;
          xor_sum  = v;
          rx_phase = sbfr_pkg::PhData;
        end
        sbfr_pkg::PhData: begin
          if (chunk_cnt < sbfr_pkg::MaxChunks) begin
            case (chunk_cnt)
              3'd0:    word_acc |= sbfr_pkg::WordW'(v) << 25;
              3'd1:    word_acc |= sbfr_pkg::WordW'(v) << 18;
              3'd2:    word_acc |= sbfr_pkg::WordW'(v) << 11;
              3'd3:    word_acc |= sbfr_pkg::WordW'(v) << 4;
              default: word_acc |= sbfr_pkg::WordW'(v) >> 3;
            endcase
            chunk_cnt = chunk_cnt + 1'b1;
            xor_sum   = xor_sum ^ v;
          end else begin
            // sixth chunk aborts the frame
            rx_phase = sbfr_pkg::PhIdle;
          end
        end
        sbfr_pkg::PhCheck: begin
          rx_phase = sbfr_pkg::PhIdle;
          if (xor_sum == v &&
              (chunk_cnt == '0 || chunk_cnt == sbfr_pkg::MaxChunks)) begin
            frame.msg_type     = cur_type;
            frame.data_word    = word_acc;
            frame.word_present = (chunk_cnt == sbfr_pkg::MaxChunks);
            pending_frames.push_back(frame);
          end
        end
        default: ;
      endcase
    end
  endtask

  // send one byte request, with random idle cycles before it
  task automatic send_byte(input logic [sbfr_pkg::ByteW-1:0] rx);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do @(posedge clk_i); while (!s_axis_tready);
    track_byte(rx);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // stop sending and wait until the receiver has nothing in flight
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_code(input logic [sbfr_pkg::CfgIdxW-1:0] idx,
                            input logic [sbfr_pkg::CodeW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sbfr_pkg::CfgStartCode) start_code = value;
    else end_code = value;
    @(negedge clk_i);
  endtask

  // one frame attempt: mostly well formed, sometimes broken, with some noise around it
  task automatic send_frame();
    logic [sbfr_pkg::CodeW-1:0] ftype;
    logic [sbfr_pkg::CodeW-1:0] chunk;
    logic [sbfr_pkg::CodeW-1:0] chk;
    int                         r;
    int                         n_chunks;
    r = $urandom_range(99);
    if (r < 60) n_chunks = 5;
    else if (r < 75) n_chunks = 0;
    else if (r < 90) n_chunks = $urandom_range(4, 1);
    else n_chunks = 6;
    // leading noise
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(3, 1)) send_byte(sbfr_pkg::ByteW'($urandom_range(255)));
    end
    send_byte({1'b1, start_code});
    ftype = sbfr_pkg::CodeW'($urandom_range(127));
    chk   = ftype;
    send_byte({1'b0, ftype});
    for (int i = 0; i < n_chunks; i++) begin
      r = $urandom_range(9);
      if (r == 0) chunk = '0;
      else if (r == 1) chunk = '1;
      else chunk = sbfr_pkg::CodeW'($urandom_range(127));
      send_byte({1'b0, chunk});
      chk ^= chunk;
      // stray control byte inside the frame
      if ($urandom_range(99) < 4) send_byte({1'b1, sbfr_pkg::CodeW'($urandom_range(127))});
    end
    if ($urandom_range(99) < 93) send_byte({1'b1, end_code});
    if ($urandom_range(99) < 15) chk ^= sbfr_pkg::CodeW'($urandom_range(127, 1));
    send_byte({1'b0, chk});
  endtask

  task automatic run_traffic(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_frame();
  endtask

  // extremes, each control case, abort and partial frames
  task automatic test_directed_frames();
    send_byte(8'h00);                // content while idle
    send_byte(8'hFF);                // unknown control code
    // frame without data
    send_byte({1'b1, start_code});
    send_byte(8'h7F);
    send_byte({1'b1, end_code});
    send_byte(8'h7F);
    // full frame, all ones
    send_byte({1'b1, start_code});
    send_byte(8'h00);
    repeat (5) send_byte(8'h7F);
    send_byte({1'b1, end_code});
    send_byte(8'h7F);
    // sixth chunk aborts, then end code and content while idle
    send_byte({1'b1, start_code});
    send_byte(8'h00);
    repeat (6) send_byte(8'h55);
    send_byte({1'b1, end_code});
    send_byte(8'h7F);
    // partial data never validates even with a matching check
    send_byte({1'b1, start_code});
    send_byte(8'h2A);
    send_byte(8'h01);
    send_byte({1'b1, end_code});
    send_byte(8'h2B);
    wait_idle();
  endtask

  // random traffic under each idle and stall pattern
  task automatic test_flow_control();
    int idle_pct[4];
    int stall_pct[4];
    idle_pct  = '{0, 57, 0, 6};
    stall_pct = '{0, 0, 57, 6};
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_pct[p];
      sink_stall_pct  = stall_pct[p];
      run_traffic(200);
      wait_idle();
    end
  endtask

  // traffic under several start and end code settings
  task automatic test_code_settings();
    logic [sbfr_pkg::CodeW-1:0] starts[5];
    logic [sbfr_pkg::CodeW-1:0] ends[5];
    starts = '{7'd0, 7'd127, 7'd5, sbfr_pkg::CodeW'($urandom_range(127)),
               sbfr_pkg::StartCodeReset};
    ends   = '{7'd127, 7'd0, 7'd5, sbfr_pkg::CodeW'($urandom_range(127)),
               sbfr_pkg::EndCodeReset};
    sender_idle_pct = 6;
    sink_stall_pct  = 6;
    for (int s = 0; s < 5; s++) begin
      write_code(sbfr_pkg::CfgStartCode, starts[s]);
      write_code(sbfr_pkg::CfgEndCode, ends[s]);
      run_traffic(80);
      wait_idle();
    end
  endtask

  // compare each delivered frame with the oldest pending one
  always @(posedge clk_i) begin
    sbfr_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected frame: msg_type %0h data_word %0h word_present %0b",
               m_axis_tdata[6:0], m_axis_tdata[38:7], m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        if (m_axis_tdata[6:0] !== want.msg_type) begin
          $error("msg_type: expected %0h, actual %0h", want.msg_type, m_axis_tdata[6:0]);
          mismatches++;
        end
        if (m_axis_tdata[38:7] !== want.data_word) begin
          $error("data_word: expected %0h, actual %0h", want.data_word, m_axis_tdata[38:7]);
          mismatches++;
        end
        if (m_axis_tuser !== want.word_present) begin
          $error("word_present: expected %0b, actual %0b", want.word_present, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = sbfr_pkg::CfgStartCode;
    cfg_wdata_i   = '0;
    start_code    = sbfr_pkg::StartCodeReset;
    end_code      = sbfr_pkg::EndCodeReset;
    rx_phase      = sbfr_pkg::PhIdle;
    chunk_cnt     = '0;
    xor_sum       = '0;
    cur_type      = '0;
    word_acc      = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_frames();
    test_flow_control();
    test_code_settings();

    wait_idle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
